// ===== hdl/lcft_pkg.sv =====
`default_nettype none

package lcft_pkg;

  // result kinds
  localparam logic [1:0] KIND_ATOM  = 2'd0;
  localparam logic [1:0] KIND_ROW_I = 2'd1;
  localparam logic [1:0] KIND_ROW_J = 2'd2;
  localparam logic [1:0] KIND_ROW_K = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_REF_X = 2'd0;
  localparam logic [1:0] REG_REF_Y = 2'd1;
  localparam logic [1:0] REG_REF_Z = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ORIGIN,
    OP_DIFFS,
    OP_MUL,
    OP_SHIFT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_LOAD_K,
    OP_DEGEN,
    OP_XD,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    SEL_CROSS,
    SEL_SQ,
    SEL_IROW,
    SEL_XFORM
  } mul_sel_t;

  typedef enum logic [1:0] {
    SRC_ORIGIN,
    SRC_ROW,
    SRC_ATOM
  } emit_src_t;

  typedef struct packed {
    dp_op_t     op;
    logic       take;
    mul_sel_t   sel;
    logic [3:0] term;
    logic [1:0] idx;
    logic       vec_k;
    emit_src_t  src;
    logic [1:0] kind;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic w_big;
    logic sq_zero;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lcft_ctrl.sv =====
`default_nettype none

module lcft_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire                 s_tlast,
  output lcft_pkg::dp_cmd_t   cmd,
  input  lcft_pkg::dp_stat_t  stat
);

  localparam int NW = FRAC_BITS + 32;
  localparam int CW = $clog2(NW);

  typedef enum logic [4:0] {
    S_IDLE, S_ORIGIN, S_EMIT_ORG, S_DIFFS, S_CROSS, S_CROSS_DRAIN, S_SCALE,
    S_SQ, S_SQ_DRAIN, S_SQRT_INIT, S_SQRT, S_CHECK, S_DIV_INIT, S_DIV,
    S_DIV_STORE, S_LOAD_K, S_IROW, S_IROW_DRAIN, S_DEGEN, S_EMIT_ROW, S_XD,
    S_XFORM, S_XFORM_DRAIN, S_EMIT_ATOM
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic [3:0]      term;
  logic [1:0]      idx;
  logic            vec_k;
  logic [1:0]      pos;
  logic            last_in;

  function automatic logic [1:0] row_kind(input logic [1:0] r);
    logic [1:0] k;
    case (r)
      2'd0:    k = lcft_pkg::KIND_ROW_I;
      2'd1:    k = lcft_pkg::KIND_ROW_J;
      default: k = lcft_pkg::KIND_ROW_K;
    endcase
    return k;
  endfunction

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.op    = lcft_pkg::OP_NOP;
    cmd.take  = 1'b0;
    cmd.sel   = lcft_pkg::SEL_CROSS;
    cmd.term  = term;
    cmd.idx   = idx;
    cmd.vec_k = vec_k;
    cmd.src   = lcft_pkg::SRC_ORIGIN;
    cmd.kind  = lcft_pkg::KIND_ATOM;
    cmd.last  = 1'b0;
    unique case (state)
      S_IDLE:        cmd.take = s_tvalid;
      S_ORIGIN:      cmd.op = lcft_pkg::OP_ORIGIN;
      S_EMIT_ORG: begin
        if (stat.out_free) cmd.op = lcft_pkg::OP_EMIT;
        cmd.src  = lcft_pkg::SRC_ORIGIN;
        cmd.last = 1'b1;
      end
      S_DIFFS:       cmd.op = lcft_pkg::OP_DIFFS;
      S_CROSS: begin
        cmd.op  = lcft_pkg::OP_MUL;
        cmd.sel = lcft_pkg::SEL_CROSS;
      end
      S_SCALE:       cmd.op = lcft_pkg::OP_SHIFT;
      S_SQ: begin
        cmd.op  = lcft_pkg::OP_MUL;
        cmd.sel = lcft_pkg::SEL_SQ;
      end
      S_SQRT_INIT:   cmd.op = lcft_pkg::OP_SQRT_INIT;
      S_SQRT:        cmd.op = lcft_pkg::OP_SQRT_STEP;
      S_DIV_INIT:    cmd.op = lcft_pkg::OP_DIV_INIT;
      S_DIV:         cmd.op = lcft_pkg::OP_DIV_STEP;
      S_DIV_STORE:   cmd.op = lcft_pkg::OP_DIV_STORE;
      S_LOAD_K:      cmd.op = lcft_pkg::OP_LOAD_K;
      S_IROW: begin
        cmd.op  = lcft_pkg::OP_MUL;
        cmd.sel = lcft_pkg::SEL_IROW;
      end
      S_DEGEN:       cmd.op = lcft_pkg::OP_DEGEN;
      S_EMIT_ROW: begin
        if (stat.out_free) cmd.op = lcft_pkg::OP_EMIT;
        cmd.src  = lcft_pkg::SRC_ROW;
        cmd.kind = row_kind(idx);
      end
      S_XD:          cmd.op = lcft_pkg::OP_XD;
      S_XFORM: begin
        cmd.op  = lcft_pkg::OP_MUL;
        cmd.sel = lcft_pkg::SEL_XFORM;
      end
      S_EMIT_ATOM: begin
        if (stat.out_free) cmd.op = lcft_pkg::OP_EMIT;
        cmd.src  = lcft_pkg::SRC_ATOM;
        cmd.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      term    <= '0;
      idx     <= '0;
      vec_k   <= 1'b0;
      pos     <= 2'd0;
      last_in <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            last_in <= s_tlast;
            term    <= '0;
            idx     <= '0;
            cnt     <= '0;
            if (pos == 2'd0)      state <= S_ORIGIN;
            else if (pos == 2'd1) state <= S_DIFFS;
            else                  state <= S_XD;
          end
        end
        S_ORIGIN:   state <= S_EMIT_ORG;
        S_EMIT_ORG: begin
          if (stat.out_free) begin
            pos   <= last_in ? 2'd0 : 2'd1;
            state <= S_IDLE;
          end
        end
        S_DIFFS: begin
          vec_k <= 1'b0;
          term  <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          term <= term + 4'd1;
          if (term == 4'd5) begin
            cnt   <= '0;
            state <= S_CROSS_DRAIN;
          end
        end
        S_CROSS_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(1)) state <= S_SCALE;
        end
        S_SCALE: begin
          if (!stat.w_big) begin
            idx   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          idx <= idx + 2'd1;
          if (idx == 2'd2) begin
            cnt   <= '0;
            state <= S_SQ_DRAIN;
          end
        end
        S_SQ_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(1)) state <= S_SQRT_INIT;
        end
        S_SQRT_INIT: begin
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(31)) state <= S_CHECK;
        end
        S_CHECK: begin
          idx <= '0;
          if (stat.sq_zero) state <= S_DEGEN;
          else              state <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) state <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          if (idx == 2'd2) begin
            idx  <= '0;
            term <= '0;
            if (vec_k) state <= S_IROW;
            else       state <= S_LOAD_K;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_DIV_INIT;
          end
        end
        S_LOAD_K: begin
          vec_k <= 1'b1;
          idx   <= '0;
          state <= S_SQ;
        end
        S_IROW: begin
          term <= term + 4'd1;
          if (term == 4'd5) begin
            cnt   <= '0;
            state <= S_IROW_DRAIN;
          end
        end
        S_IROW_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(1)) begin
            idx   <= '0;
            state <= S_EMIT_ROW;
          end
        end
        S_DEGEN: begin
          idx   <= '0;
          state <= S_EMIT_ROW;
        end
        S_EMIT_ROW: begin
          if (stat.out_free) begin
            idx <= idx + 2'd1;
            if (idx == 2'd2) state <= S_XD;
          end
        end
        S_XD: begin
          term  <= '0;
          state <= S_XFORM;
        end
        S_XFORM: begin
          term <= term + 4'd1;
          if (term == 4'd8) begin
            cnt   <= '0;
            state <= S_XFORM_DRAIN;
          end
        end
        S_XFORM_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(1)) state <= S_EMIT_ATOM;
        end
        S_EMIT_ATOM: begin
          if (stat.out_free) begin
            pos   <= last_in ? 2'd0 : 2'd2;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcft_dp.sv =====
`default_nettype none

module lcft_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [1:0]           cfg_addr,
  input  wire [31:0]          cfg_data,
  input  wire [95:0]          s_tdata,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [95:0]         m_tdata,
  output logic                m_tlast,
  output logic [2:0]          m_tuser,
  input  lcft_pkg::dp_cmd_t   cmd,
  output lcft_pkg::dp_stat_t  stat
);

  localparam int FW = FRAC_BITS + 2;
  localparam int NW = FRAC_BITS + 32;
  localparam int MW = 34;
  localparam int AW = 66;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SMAX = AW'(32'h7fff_ffff);
  localparam logic signed [AW-1:0] SMIN = {{(AW-31){1'b1}}, 31'b0};

  logic signed [31:0]    ref_pt [3];
  logic signed [31:0]    org    [3];
  logic signed [31:0]    xin    [3];
  logic signed [31:0]    vd     [3];
  logic signed [31:0]    ve     [3];
  logic signed [32:0]    xd     [3];
  logic signed [FW-1:0]  fi     [3];
  logic signed [FW-1:0]  fj     [3];
  logic signed [FW-1:0]  fk     [3];
  logic signed [31:0]    xr     [3];
  logic                  deg;
  logic                  w_sgn  [3];
  logic [63:0]           w_mag  [3];

  logic signed [31:0]    vd_n   [3];
  logic signed [31:0]    ve_n   [3];

  logic signed [MW-1:0]   op_a, op_b;
  logic signed [2*MW-1:0] mprod;
  logic                   m_clr, m_neg, m_fin;
  logic [1:0]             m_row;
  logic signed [AW-1:0]   prod, acc, acc_r, rnd, acc_mag;
  logic                   p_v, p_clr, p_neg, p_fin, a_fin;
  lcft_pkg::mul_sel_t     p_sel, a_sel;
  logic [1:0]             p_row, a_row;

  logic [63:0]            sq_x, sq_res, sq_bit, sq_t;
  logic [NW-1:0]          dv_num;
  logic [31:0]            dv_rem;
  logic [32:0]            dv_r2, dv_diff;
  logic                   dv_ge;
  logic signed [FW-1:0]   qv;
  logic [63:0]            w_rd;

  logic [1:0]             kind_r;
  logic                   last_r;
  logic signed [31:0]     oa, ob, oc;
  logic                   odeg;

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic signed [31:0] r;
    if (v > SMAX)      r = 32'sh7fff_ffff;
    else if (v < SMIN) r = 32'sh8000_0000;
    else               r = v[31:0];
    return r;
  endfunction

  function automatic logic [1:0] xf_row(input logic [3:0] t);
    logic [1:0] r;
    if (t >= 4'd6)      r = 2'd2;
    else if (t >= 4'd3) r = 2'd1;
    else                r = 2'd0;
    return r;
  endfunction

  function automatic logic signed [31:0] ext32(input logic signed [FW-1:0] v);
    return {{(32-FW){v[FW-1]}}, v};
  endfunction

  function automatic logic signed [MW-1:0] extf(input logic signed [FW-1:0] v);
    return {{(MW-FW){v[FW-1]}}, v};
  endfunction

  // scale a difference vector so every magnitude is below 2^31
  always_comb begin
    logic signed [32:0] dd [3];
    logic signed [32:0] de [3];
    logic [32:0] dm [3];
    logic [32:0] em [3];
    logic ds, es;
    ds = 1'b0;
    es = 1'b0;
    for (int c = 0; c < 3; c++) begin
      dd[c] = {ref_pt[c][31], ref_pt[c]} - {org[c][31], org[c]};
      de[c] = {xin[c][31], xin[c]} - {org[c][31], org[c]};
      dm[c] = dd[c][32] ? 33'(-dd[c]) : 33'(dd[c]);
      em[c] = de[c][32] ? 33'(-de[c]) : 33'(de[c]);
      ds = ds | (dm[c][32:31] != 2'b00);
      es = es | (em[c][32:31] != 2'b00);
    end
    for (int c = 0; c < 3; c++) begin
      dm[c] = ds ? (dm[c] >> 1) : dm[c];
      em[c] = es ? (em[c] >> 1) : em[c];
      vd_n[c] = dd[c][32] ? -$signed(dm[c][31:0]) : $signed(dm[c][31:0]);
      ve_n[c] = de[c][32] ? -$signed(em[c][31:0]) : $signed(em[c][31:0]);
    end
  end

  assign w_rd = w_mag[cmd.idx];

  // multiplier operand selection and term bookkeeping
  always_comb begin
    logic [1:0] ai, bi, xc;
    ai = 2'd0;
    bi = 2'd0;
    case (cmd.term)
      4'd0:    begin ai = 2'd1; bi = 2'd2; end
      4'd1:    begin ai = 2'd2; bi = 2'd1; end
      4'd2:    begin ai = 2'd2; bi = 2'd0; end
      4'd3:    begin ai = 2'd0; bi = 2'd2; end
      4'd4:    begin ai = 2'd0; bi = 2'd1; end
      default: begin ai = 2'd1; bi = 2'd0; end
    endcase
    xc = 2'(cmd.term - {xf_row(cmd.term), 2'b00} + {2'b00, xf_row(cmd.term)});
    op_a  = '0;
    op_b  = '0;
    m_clr = 1'b0;
    m_neg = 1'b0;
    m_fin = 1'b0;
    m_row = 2'd0;
    case (cmd.sel)
      lcft_pkg::SEL_CROSS: begin
        op_a  = {{2{vd[ai][31]}}, vd[ai]};
        op_b  = {{2{ve[bi][31]}}, ve[bi]};
        m_clr = ~cmd.term[0];
        m_neg = cmd.term[0];
        m_fin = cmd.term[0];
        m_row = cmd.term[2:1];
      end
      lcft_pkg::SEL_SQ: begin
        op_a  = {2'b00, w_rd[31:0]};
        op_b  = {2'b00, w_rd[31:0]};
        m_clr = (cmd.idx == 2'd0);
        m_fin = (cmd.idx == 2'd2);
      end
      lcft_pkg::SEL_IROW: begin
        op_a  = extf(fj[ai]);
        op_b  = extf(fk[bi]);
        m_clr = ~cmd.term[0];
        m_neg = cmd.term[0];
        m_fin = cmd.term[0];
        m_row = cmd.term[2:1];
      end
      default: begin
        case (xf_row(cmd.term))
          2'd0:    op_a = extf(fi[xc]);
          2'd1:    op_a = extf(fj[xc]);
          default: op_a = extf(fk[xc]);
        endcase
        op_b  = {xd[xc][32], xd[xc]};
        m_clr = (xc == 2'd0);
        m_fin = (xc == 2'd2);
        m_row = xf_row(cmd.term);
      end
    endcase
  end

  assign mprod   = op_a * op_b;
  assign acc_r   = acc + HALF;
  assign rnd     = acc_r >>> FRAC_BITS;
  assign acc_mag = acc[AW-1] ? -acc : acc;

  // multiply, accumulate, then write back the finished sum
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v   <= 1'b0;
      a_fin <= 1'b0;
    end else begin
      p_v   <= (cmd.op == lcft_pkg::OP_MUL);
      a_fin <= p_v & p_fin;
    end
    prod  <= $signed(mprod[AW-1:0]);
    p_clr <= m_clr;
    p_neg <= m_neg;
    p_fin <= m_fin;
    p_sel <= cmd.sel;
    p_row <= m_row;
    if (p_v) acc <= (p_clr ? '0 : acc) + (p_neg ? -prod : prod);
    a_sel <= p_sel;
    a_row <= p_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) ref_pt[c] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lcft_pkg::REG_REF_X: ref_pt[0] <= cfg_data;
        lcft_pkg::REG_REF_Y: ref_pt[1] <= cfg_data;
        lcft_pkg::REG_REF_Z: ref_pt[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      xin[0] <= s_tdata[31:0];
      xin[1] <= s_tdata[63:32];
      xin[2] <= s_tdata[95:64];
    end
    if (cmd.op == lcft_pkg::OP_ORIGIN) begin
      for (int c = 0; c < 3; c++) org[c] <= xin[c];
    end
    if (cmd.op == lcft_pkg::OP_DIFFS) begin
      for (int c = 0; c < 3; c++) begin
        vd[c] <= vd_n[c];
        ve[c] <= ve_n[c];
      end
    end
    if (cmd.op == lcft_pkg::OP_XD) begin
      for (int c = 0; c < 3; c++) xd[c] <= {xin[c][31], xin[c]} - {org[c][31], org[c]};
    end
    if (a_fin && a_sel == lcft_pkg::SEL_XFORM) xr[a_row] <= sat32(rnd);
  end

  // working vector for unit-length normalization, sign and magnitude
  always_ff @(posedge clk) begin
    if (a_fin && a_sel == lcft_pkg::SEL_CROSS) begin
      w_sgn[a_row] <= acc[AW-1];
      w_mag[a_row] <= acc_mag[63:0];
    end else if (cmd.op == lcft_pkg::OP_SHIFT && stat.w_big) begin
      for (int c = 0; c < 3; c++) w_mag[c] <= w_mag[c] >> 1;
    end else if (cmd.op == lcft_pkg::OP_LOAD_K) begin
      for (int c = 0; c < 3; c++) begin
        w_sgn[c] <= vd[c][31];
        w_mag[c] <= 64'(vd[c][31] ? -vd[c] : vd[c]);
      end
    end
  end

  assign stat.w_big    = (w_mag[0][63:31] != '0) || (w_mag[1][63:31] != '0)
                         || (w_mag[2][63:31] != '0);
  assign stat.sq_zero  = (sq_res == '0);
  assign stat.out_free = ~m_tvalid | m_tready;

  // bit-pair square root
  assign sq_t = sq_res + sq_bit;
  always_ff @(posedge clk) begin
    if (cmd.op == lcft_pkg::OP_SQRT_INIT) begin
      sq_x   <= acc[63:0];
      sq_res <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
    end else if (cmd.op == lcft_pkg::OP_SQRT_STEP) begin
      if (sq_x >= sq_t) begin
        sq_x   <= sq_x - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign dv_r2   = {dv_rem, dv_num[NW-1]};
  assign dv_diff = dv_r2 - {1'b0, sq_res[31:0]};
  assign dv_ge   = (dv_r2 >= {1'b0, sq_res[31:0]});
  assign qv      = {1'b0, dv_num[FW-2:0]};

  always_ff @(posedge clk) begin
    if (cmd.op == lcft_pkg::OP_DIV_INIT) begin
      dv_num <= (NW'(w_rd[30:0]) << FRAC_BITS) + NW'(sq_res[31:1]);
      dv_rem <= '0;
    end else if (cmd.op == lcft_pkg::OP_DIV_STEP) begin
      dv_rem <= dv_ge ? dv_diff[31:0] : dv_r2[31:0];
      dv_num <= {dv_num[NW-2:0], dv_ge};
    end
  end

  // frame rows
  always_ff @(posedge clk) begin
    if (cmd.op == lcft_pkg::OP_ORIGIN || cmd.op == lcft_pkg::OP_DEGEN) begin
      for (int c = 0; c < 3; c++) begin
        fi[c] <= '0;
        fj[c] <= '0;
        fk[c] <= '0;
      end
      deg <= (cmd.op == lcft_pkg::OP_DEGEN);
    end else if (cmd.op == lcft_pkg::OP_DIV_STORE) begin
      if (cmd.vec_k) fk[cmd.idx] <= w_sgn[cmd.idx] ? -qv : qv;
      else           fj[cmd.idx] <= w_sgn[cmd.idx] ? -qv : qv;
    end else if (a_fin && a_sel == lcft_pkg::SEL_IROW) begin
      fi[a_row] <= rnd[FW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == lcft_pkg::OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.op == lcft_pkg::OP_EMIT) begin
      kind_r <= cmd.kind;
      last_r <= cmd.last;
      case (cmd.src)
        lcft_pkg::SRC_ROW: begin
          odeg <= deg;
          case (cmd.idx)
            2'd0: begin oa <= ext32(fi[0]); ob <= ext32(fi[1]); oc <= ext32(fi[2]); end
            2'd1: begin oa <= ext32(fj[0]); ob <= ext32(fj[1]); oc <= ext32(fj[2]); end
            default: begin
              oa <= ext32(fk[0]);
              ob <= ext32(fk[1]);
              oc <= ext32(fk[2]);
            end
          endcase
        end
        lcft_pkg::SRC_ATOM: begin
          odeg <= deg;
          oa   <= xr[0];
          ob   <= xr[1];
          oc   <= xr[2];
        end
        default: begin
          odeg <= 1'b0;
          oa   <= '0;
          ob   <= '0;
          oc   <= '0;
        end
      endcase
    end
  end

  assign m_tdata = {oc, ob, oa};
  assign m_tlast = last_r;
  assign m_tuser = {odeg, kind_r};

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lcft_pkg::OP_EMIT |-> stat.out_free)
    else $error("result loaded over one not yet taken");

  a_sq_norm: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == lcft_pkg::OP_MUL && cmd.sel == lcft_pkg::SEL_SQ) |-> !stat.w_big)
    else $error("squaring a vector that is not scaled down");

  a_root_fit: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lcft_pkg::OP_DIV_INIT |-> sq_res[63:32] == '0)
    else $error("vector length exceeds 32 bits");

  a_quot_fit: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lcft_pkg::OP_DIV_STORE |-> dv_num[NW-1:FW-1] == '0)
    else $error("unit component above one");

endmodule

`default_nettype wire

// ===== hdl/local_frame_coordinate_transform.sv =====
`default_nettype none

// local frame transform for one rigid cluster. atoms arrive as Q15.16
// (FRAC_BITS fraction bits) x/y/z; the first atom of a cluster is the
// origin O and gives a zero atom result, the second is the neighbour H.
// on H the block builds the frame k = unit(P - O), j = unit((P-O) x (H-O)),
// i = j x k, with P taken from the ref_x/ref_y/ref_z registers, sends the
// rows i, j, k and then the atom; every later atom X gives R(X - O).
// a zero length or a zero cross product gives an all-zero frame and sets
// the degenerate flag until the next origin. one request is taken at a
// time: a following atom makes 9 passes of the single 34x34 multiplier,
// and the neighbour atom runs two 32-step square roots and six
// (FRAC_BITS + 32)-step divides plus shift scaling of the cross product.
// a finished result sits in an output register so the next request is
// taken while it waits. the user must write configuration only while the
// block is idle; the block itself does not enforce this.

module local_frame_coordinate_transform #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  // configuration writes
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [31:0] cfg_data,
  // atom requests
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [95:0] s_tdata,   // pos_x, pos_y, pos_z
  input  wire         s_tlast,   // last atom of the cluster
  // results
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [95:0] m_tdata,   // val_a, val_b, val_c
  output logic        m_tlast,   // final result of this request
  output logic [2:0]  m_tuser    // kind [1:0], degenerate [2]
);

  lcft_pkg::dp_cmd_t  cmd;
  lcft_pkg::dp_stat_t stat;

  // sequencer: walks each request through the datapath operations
  lcft_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: shared multiplier, root and divide units, frame and output
  lcft_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// ===== sim/lcft_checker.sv =====
`timescale 1ns / 100ps

module lcft_checker #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [31:0] cfg_data,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [95:0] s_tdata,
  input  wire         s_tlast,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [95:0] m_tdata,
  input  wire         m_tlast,
  input  wire  [2:0]  m_tuser,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        deg;
    logic        last;
  } xform_result_t;

  xform_result_t awaited_results[$];

  logic signed [31:0] ref_pt [3];
  longint origin [3];
  longint rows [9];
  int     atom_idx;
  logic   degen;

  function automatic longint round_q(longint v);
    return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // shrink magnitudes until all fit below 2^31
  function automatic void shrink(input longint v [3], output longint o [3]);
    bit [63:0] mag [3];
    bit [63:0] m;
    int s;
    m = 0;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      mag[c] = v[c] < 0 ? -v[c] : v[c];
      if (mag[c] > m) m = mag[c];
    end
    while ((m >> s) >= 64'h80000000) s++;
    for (int c = 0; c < 3; c++) o[c] = v[c] < 0 ? -longint'(mag[c] >> s) : longint'(mag[c] >> s);
  endfunction

  function automatic bit normalize(input longint v [3], output longint o [3]);
    longint p [3];
    bit [63:0] sum, n, mg, q;
    shrink(v, p);
    sum = 0;
    for (int c = 0; c < 3; c++) sum = sum + 64'(p[c] * p[c]);
    n = floor_sqrt(sum);
    if (n == 0) begin
      for (int c = 0; c < 3; c++) o[c] = 0;
      return 0;
    end
    for (int c = 0; c < 3; c++) begin
      mg = p[c] < 0 ? -p[c] : p[c];
      q = ((mg << FRAC_BITS) + n / 2) / n;
      o[c] = p[c] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void build_frame(input longint h [3]);
    longint d [3], e [3], pd [3], pe [3], cr [3], jv [3], kv [3];
    bit okj, okk;
    for (int c = 0; c < 3; c++) begin
      d[c] = longint'(ref_pt[c]) - origin[c];
      e[c] = h[c] - origin[c];
    end
    shrink(d, pd);
    shrink(e, pe);
    cr[0] = pd[1] * pe[2] - pd[2] * pe[1];
    cr[1] = pd[2] * pe[0] - pd[0] * pe[2];
    cr[2] = pd[0] * pe[1] - pd[1] * pe[0];
    okj = normalize(cr, jv);
    okk = normalize(d, kv);
    if (!okj || !okk) begin
      for (int c = 0; c < 9; c++) rows[c] = 0;
      degen = 1;
      return;
    end
    rows[0] = round_q(jv[1] * kv[2] - jv[2] * kv[1]);
    rows[1] = round_q(jv[2] * kv[0] - jv[0] * kv[2]);
    rows[2] = round_q(jv[0] * kv[1] - jv[1] * kv[0]);
    for (int c = 0; c < 3; c++) begin
      rows[3 + c] = jv[c];
      rows[6 + c] = kv[c];
    end
    degen = 0;
  endfunction

  function automatic void push_result(logic [1:0] kind, longint a, longint b, longint c,
                                      logic deg, logic last);
    xform_result_t r;
    r.kind = kind;
    r.a = sat(a);
    r.b = sat(b);
    r.c = sat(c);
    r.deg = deg;
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_atom(logic [95:0] data, logic last_atom);
    longint x [3], diff [3], v [3], acc;
    for (int c = 0; c < 3; c++) x[c] = longint'($signed(data[32 * c +: 32]));
    if (atom_idx == 0) begin
      for (int c = 0; c < 3; c++) origin[c] = x[c];
      for (int c = 0; c < 9; c++) rows[c] = 0;
      degen = 0;
      push_result(lcft_pkg::KIND_ATOM, 0, 0, 0, 0, 1);
      atom_idx = last_atom ? 0 : 1;
      return;
    end
    if (atom_idx == 1) begin
      build_frame(x);
      push_result(lcft_pkg::KIND_ROW_I, rows[0], rows[1], rows[2], degen, 0);
      push_result(lcft_pkg::KIND_ROW_J, rows[3], rows[4], rows[5], degen, 0);
      push_result(lcft_pkg::KIND_ROW_K, rows[6], rows[7], rows[8], degen, 0);
    end
    for (int c = 0; c < 3; c++) diff[c] = x[c] - origin[c];
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) acc += rows[r * 3 + c] * diff[c];
      v[r] = round_q(acc);
    end
    push_result(lcft_pkg::KIND_ATOM, v[0], v[1], v[2], degen, 1);
    atom_idx = last_atom ? 0 : 2;
  endfunction

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    xform_result_t want;
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        ref_pt[c] <= 0;
        origin[c] = 0;
      end
      for (int c = 0; c < 9; c++) rows[c] = 0;
      atom_idx = 0;
      degen = 0;
      errors <= 0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          lcft_pkg::REG_REF_X: ref_pt[0] <= cfg_data;
          lcft_pkg::REG_REF_Y: ref_pt[1] <= cfg_data;
          lcft_pkg::REG_REF_Z: ref_pt[2] <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_atom(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          if (errors < 10) $display("unexpected result: tdata %h tuser %h", m_tdata, m_tuser);
          errors <= errors + 1;
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser[1:0] !== want.kind || m_tdata[31:0] !== want.a ||
              m_tdata[63:32] !== want.b || m_tdata[95:64] !== want.c ||
              m_tuser[2] !== want.deg || m_tlast !== want.last) begin
            if (errors < 10)
              $display("mismatch: want kind %0d a %h b %h c %h deg %b last %b, got kind %0d a %h b %h c %h deg %b last %b",
                       want.kind, want.a, want.b, want.c, want.deg, want.last,
                       m_tuser[1:0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                       m_tuser[2], m_tlast);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/local_frame_coordinate_transform_tb.sv =====
`timescale 1ns / 100ps

module local_frame_coordinate_transform_tb;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;

  int errors;
  int pending;
  int cycles = 0;
  int stall_left;
  bit no_idle;

  // current reference point, kept to aim special cases
  logic signed [31:0] cur_ref [3];

  local_frame_coordinate_transform DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  lcft_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("local_frame_coordinate_transform verification failed");
      $finish;
    end
  end

  // receiver back-pressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst || no_idle) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
    end
  end

  // write the reference point, three back-to-back register writes
  task automatic write_ref(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    cfg_we <= 1'b1;
    cfg_addr <= lcft_pkg::REG_REF_X;
    cfg_data <= rx;
    @(posedge clk);
    cfg_addr <= lcft_pkg::REG_REF_Y;
    cfg_data <= ry;
    @(posedge clk);
    cfg_addr <= lcft_pkg::REG_REF_Z;
    cfg_data <= rz;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_ref[0] = rx;
    cur_ref[1] = ry;
    cur_ref[2] = rz;
    @(posedge clk);
  endtask

  // one atom request; valid stays high when the next one follows without a gap
  task automatic send_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last_atom);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x};
    s_tlast <= last_atom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drain all results, then let the block settle before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] coord(bit full);
    if (full) return $urandom;
    return $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
  endfunction

  // well-formed cluster of random size with random content
  task automatic send_cluster(int n, bit full);
    for (int i = 0; i < n; i++)
      send_atom(coord(full), coord(full), coord(full), i == n - 1);
  endtask

  initial begin
    int sent;
    int n;
    logic [31:0] ox, oy, oz;
    no_idle = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = lcft_pkg::REG_REF_X;
    cfg_data = 0;
    s_tvalid = 1'b0;
    s_tdata = 0;
    s_tlast = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset reference point (zero)
    cur_ref[0] = 0;
    cur_ref[1] = 0;
    cur_ref[2] = 0;
    // one-atom cluster
    send_atom(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
    // reference point equals origin: zero k length
    send_atom(0, 0, 0, 1'b0);
    send_atom(32'h0001_0000, 0, 0, 1'b0);
    send_atom(32'h0000_8000, 32'hffff_0000, 32'h0004_0000, 1'b1);
    // neighbour equals origin
    send_atom(32'h0003_0000, 32'h0001_0000, 0, 1'b0);
    send_atom(32'h0003_0000, 32'h0001_0000, 0, 1'b1);
    // neighbour on the line through origin and reference point
    send_atom(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 1'b0);
    send_atom(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 1'b0);
    send_atom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    // extreme coordinates, forces prescaling and saturation
    send_atom(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_atom(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_atom(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    // ordinary cluster
    send_atom(32'h0001_0000, 0, 0, 1'b0);
    send_atom(0, 32'h0001_0000, 0, 1'b0);
    send_atom(0, 0, 32'h0001_0000, 1'b0);
    send_atom(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    settle();

    // extreme reference points
    write_ref(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_atom(32'h8000_0000, 32'h7fff_ffff, 0, 1'b0);
    send_atom(0, 0, 0, 1'b1);
    settle();
    write_ref(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_atom(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_atom(0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_atom(32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f, 1'b1);
    settle();

    // random phases, each with its own reference point
    sent = 0;
    for (int ph = 0; sent < 440; ph++) begin
      case (ph % 4)
        0: write_ref(coord(0), coord(0), coord(0));
        1: write_ref($urandom, $urandom, $urandom);
        2: write_ref(0, 0, 0);
        default: write_ref(32'h7fff_ffff, 32'h8000_0000, coord(0));
      endcase
      no_idle = (ph % 5 == 4);
      for (int cl = 0; cl < 12; cl++) begin
        n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
        case ($urandom_range(0, 9))
          0: send_cluster(n, 1);
          1: begin
            // degenerate by construction: origin on the reference point
            send_atom(cur_ref[0], cur_ref[1], cur_ref[2], 1'b0);
            send_atom(coord(0), coord(0), coord(0), 1'b1);
            n = 2;
          end
          2: begin
            // neighbour repeats the origin
            ox = coord(0);
            oy = coord(0);
            oz = coord(0);
            send_atom(ox, oy, oz, 1'b0);
            send_atom(ox, oy, oz, 1'b0);
            send_atom(coord(0), coord(0), coord(0), 1'b1);
            n = 3;
          end
          3: begin
            // broken sequence: atoms of mixed range, random last flags
            for (int i = 0; i < n; i++)
              send_atom(coord($urandom_range(0, 1)), coord(0), coord(1), $urandom_range(0, 1));
          end
          default: send_cluster(n, 0);
        endcase
        sent += n;
      end
      settle();
    end
    // leave the register at rest in a final setting
    write_ref(0, 0, 0);
    no_idle = 0;
    send_cluster(4, 0);
    settle();

    if (errors == 0 && pending == 0) begin
      $display("local_frame_coordinate_transform verification clean");
    end else begin
      $display("local_frame_coordinate_transform verification failed");
    end
    $finish;
  end

endmodule
